// File: src/aesc_pkg.sv
// ----------------------------------------------------------------------------
// aesc_pkg
// Shared types, S-box tables and round transforms for the AES-128 core.
// ----------------------------------------------------------------------------
package aesc_pkg;

	localparam int NR = 10;

	typedef logic [127:0]        blk_t;
	typedef logic [NR:0][127:0]  rkeys_t;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1
	} reg_idx_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
		8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
		8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
		8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
		8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
		8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
		8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
		8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
		8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
		8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
		8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
		8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
		8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
		8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
		8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
		8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
		8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
		8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
		8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
		8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
		8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
		8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
		8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
		8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
		8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
		8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
		8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
		8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
		8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
		8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
		8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
		8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
	};

	// multiply by x in GF(2^8)
	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a block, byte 0 in the top bits
	function automatic logic [7:0] get_byte(input blk_t b, input int i);
		get_byte = b[127 - 8*i -: 8];
	endfunction

	function automatic blk_t sub_bytes(input blk_t b, input logic inv);
		blk_t r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			r[127 - 8*i -: 8] = inv ? INV_SBOX[get_byte(b, i)] : SBOX[get_byte(b, i)];
		end
		sub_bytes = r;
	endfunction

	// byte r + 4c takes row r, column c
	function automatic blk_t shift_rows(input blk_t b, input logic inv);
		blk_t r;
		int   src;
		r = b;
		for (int row = 1; row < 4; row++) begin
			for (int c = 0; c < 4; c++) begin
				src = inv ? ((c - row + 4) % 4) : ((c + row) % 4);
				r[127 - 8*(row + 4*c) -: 8] = get_byte(b, row + 4*src);
			end
		end
		shift_rows = r;
	endfunction

	function automatic blk_t mix_columns(input blk_t b, input logic inv);
		blk_t       r;
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] m9 [4];
		logic [7:0] m11 [4];
		logic [7:0] m13 [4];
		logic [7:0] m14 [4];
		logic [7:0] m3 [4];
		r = '0;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k]   = get_byte(b, 4*c + k);
				a2[k]  = xt(a[k]);
				a4[k]  = xt(a2[k]);
				a8[k]  = xt(a4[k]);
				m3[k]  = a2[k] ^ a[k];
				m9[k]  = a8[k] ^ a[k];
				m11[k] = a8[k] ^ a2[k] ^ a[k];
				m13[k] = a8[k] ^ a4[k] ^ a[k];
				m14[k] = a8[k] ^ a4[k] ^ a2[k];
			end
			for (int row = 0; row < 4; row++) begin
				if (inv) begin
					r[127 - 8*(4*c + row) -: 8] = m14[row] ^ m11[(row + 1) % 4]
						^ m13[(row + 2) % 4] ^ m9[(row + 3) % 4];
				end else begin
					r[127 - 8*(4*c + row) -: 8] = a2[row] ^ m3[(row + 1) % 4]
						^ a[(row + 2) % 4] ^ a[(row + 3) % 4];
				end
			end
		end
		mix_columns = r;
	endfunction

	// one cipher round; decrypt follows the plain inverse cipher order
	function automatic blk_t aes_round(input blk_t b, input blk_t key,
			input logic dec, input logic last);
		blk_t t;
		if (dec) begin
			t = sub_bytes(shift_rows(b, 1'b1), 1'b1) ^ key;
			if (!last) t = mix_columns(t, 1'b1);
		end else begin
			t = shift_rows(sub_bytes(b, 1'b0), 1'b0);
			if (!last) t = mix_columns(t, 1'b0);
			t = t ^ key;
		end
		aes_round = t;
	endfunction

	// next four schedule words from the previous four
	function automatic blk_t key_step(input blk_t w, input logic [7:0] rc);
		logic [31:0] rw;
		logic [31:0] t;
		logic [31:0] n0;
		logic [31:0] n1;
		logic [31:0] n2;
		logic [31:0] n3;
		rw = {w[23:0], w[31:24]};
		t  = {SBOX[rw[31:24]] ^ rc, SBOX[rw[23:16]], SBOX[rw[15:8]], SBOX[rw[7:0]]};
		n0 = w[127:96] ^ t;
		n1 = w[95:64] ^ n0;
		n2 = w[63:32] ^ n1;
		n3 = w[31:0] ^ n2;
		key_step = {n0, n1, n2, n3};
	endfunction

endpackage

// File: src/aes128_block_cipher_core.sv
// ----------------------------------------------------------------------------
// aes128_block_cipher_core
// AES-128 ECB encrypt/decrypt, ten unrolled round stages.
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------
//   input     start / busy         action, block_high, block_low
//   result    out_valid (strobe)   out_high, out_low
//   config    cfg_we               cfg_index, cfg_wdata
//
// One transaction accepted per cycle while busy is low; its result strobes
// once it has passed the key-add stage and one stage per round.
// After reset and after each key write the key schedule is rebuilt,
// one round key per cycle; busy is high meanwhile.
// Results cannot be stalled; the pipeline always advances.
// ----------------------------------------------------------------------------
module aes128_block_cipher_core import aesc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	rkeys_t rkeys;
	logic   accept;
	logic   valid_s0;
	logic   dec_s0;
	blk_t   st_s0;
	logic   pv_s [NR+1];
	logic   pd_s [NR+1];
	blk_t   ps_s [NR+1];

	aesc_key_exp u_key_exp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.round_keys (rkeys),
		.busy       (busy)
	);

	assign accept = start && !busy;

	// initial key add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s0 <= 1'b0;
		else         valid_s0 <= accept;
	end

	always_ff @(posedge clk) begin
		dec_s0 <= action;
		st_s0  <= {block_high, block_low} ^ (action ? rkeys[NR] : rkeys[0]);
	end

	assign pv_s[0] = valid_s0;
	assign pd_s[0] = dec_s0;
	assign ps_s[0] = st_s0;

	// round stages; decrypt walks the schedule backwards
	for (genvar k = 1; k <= NR; k++) begin : g_round
		aesc_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (pv_s[k-1]),
			.in_dec    (pd_s[k-1]),
			.in_state  (ps_s[k-1]),
			.key       (pd_s[k-1] ? rkeys[NR-k] : rkeys[k]),
			.last      (k == NR),
			.out_valid (pv_s[k]),
			.out_dec   (pd_s[k]),
			.out_state (ps_s[k])
		);
	end

	assign out_valid = pv_s[NR];
	assign out_high  = ps_s[NR][127:64];
	assign out_low   = ps_s[NR][63:0];

endmodule

// File: src/aesc_key_exp.sv
// ----------------------------------------------------------------------------
// aesc_key_exp
// Key registers and the round-key expander, one round key per cycle.
// ----------------------------------------------------------------------------
module aesc_key_exp import aesc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	output rkeys_t      round_keys,
	output logic        busy
);

	typedef enum logic [2:0] {
		KS_LOAD = 3'b001,
		KS_RUN  = 3'b010,
		KS_IDLE = 3'b100
	} ks_state_t;

	ks_state_t   state_q;
	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [3:0]  cnt_q;
	logic [7:0]  rc_q;
	blk_t        work_q;
	rkeys_t      rk_q;
	blk_t        next_w;
	logic        key_wr;

	assign key_wr = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
	assign next_w = key_step(work_q, rc_q);

	// key registers and schedule sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= KS_LOAD;
			key_high_q <= '0;
			key_low_q  <= '0;
			cnt_q      <= '0;
			rc_q       <= '0;
		end else if (key_wr) begin
			if (cfg_index == REG_KEY_HIGH) key_high_q <= cfg_wdata;
			else                           key_low_q  <= cfg_wdata;
			state_q <= KS_LOAD;
		end else begin
			case (state_q)
				KS_LOAD: begin
					cnt_q   <= 4'd1;
					rc_q    <= 8'h01;
					state_q <= KS_RUN;
				end
				KS_RUN: begin
					rc_q  <= xt(rc_q);
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(NR)) state_q <= KS_IDLE;
				end
				KS_IDLE: ;
				default: state_q <= KS_LOAD;
			endcase
		end
	end

	// schedule storage, no reset needed: rebuilt after every reset
	always_ff @(posedge clk) begin
		if (!key_wr && state_q == KS_LOAD) begin
			work_q   <= {key_high_q, key_low_q};
			rk_q[0]  <= {key_high_q, key_low_q};
		end else if (!key_wr && state_q == KS_RUN) begin
			work_q        <= next_w;
			rk_q[cnt_q]   <= next_w;
		end
	end

	assign round_keys = rk_q;
	assign busy       = (state_q != KS_IDLE);

endmodule

// File: src/aesc_round.sv
// ----------------------------------------------------------------------------
// aesc_round
// One registered cipher round of the unrolled pipeline.
// ----------------------------------------------------------------------------
module aesc_round import aesc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_dec,
	input  blk_t in_state,
	input  blk_t key,
	input  logic last,
	output logic out_valid,
	output logic out_dec,
	output blk_t out_state
);

	logic valid_q;
	logic dec_q;
	blk_t state_q;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else         valid_q <= in_valid;
	end

	// payload
	always_ff @(posedge clk) begin
		dec_q   <= in_dec;
		state_q <= aes_round(in_state, key, in_dec, last);
	end

	assign out_valid = valid_q;
	assign out_dec   = dec_q;
	assign out_state = state_q;

endmodule

// File: src/aesc_checker.sv
// ----------------------------------------------------------------------------
// aesc_checker
// Port-level checks on the AES-128 core, bound to the top level.
// ----------------------------------------------------------------------------
module aesc_checker import aesc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       out_valid,
	input logic       cfg_we,
	input logic [1:0] cfg_index
);

	// every accepted transaction strobes a result at the end of the pipeline
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##11 out_valid)
		else $error("result strobe missing");

	// no result without an accepted transaction
	a_no_spur: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(start && !busy, 11))
		else $error("unexpected result strobe");

	// a key write starts a schedule rebuild
	a_key_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW)) |=> busy)
		else $error("busy not raised after key write");

	// a schedule rebuild does not finish early
	a_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(busy, 10))
		else $error("key schedule finished early");

endmodule

bind aes128_block_cipher_core aesc_checker u_aesc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.out_valid (out_valid),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index)
);

// File: tb/sv/aes128_block_cipher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_cipher_core_tb
// Self-checking bench for the AES-128 ECB core. Blocks are queued by an
// initial block, driven on the start/busy handshake at the falling edge and
// checked against a behavioral AES model (own S-box, key schedule, forward
// and inverse cipher) as each result strobes. Keys are rewritten between
// phases once the pipeline has drained.
// ----------------------------------------------------------------------------
module aes128_block_cipher_core_tb;
	import aesc_pkg::*;

	localparam int        WATCHDOG_CYCLES = 5000;
	localparam int        DRAIN_CYCLES    = 30;
	// indexes past key_low: writes there must be ignored
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;
	localparam logic       ACT_ENC = 1'b0;
	localparam logic       ACT_DEC = 1'b1;

	typedef enum logic [1:0] {ENT_BLOCK, ENT_KEY, ENT_DRAIN} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		logic        act;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [1:0]  idx;
		int          gap;
	} entry_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        out_valid;
	logic [63:0] out_high;
	logic [63:0] out_low;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;

	entry_t      pending_q[$];
	blk_t        expected_q[$];
	int          err_cnt;
	int          idle_cnt;
	bit          took;
	int          gap_left;
	bit          armed;

	// model state
	logic [7:0]  fwd_sbox [256];
	logic [7:0]  inv_sbox [256];
	logic [63:0] key_hi;
	logic [63:0] key_lo;
	logic [31:0] sched [44];

	aes128_block_cipher_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.block_high(block_high),
		.block_low (block_low),
		.out_valid (out_valid),
		.out_high  (out_high),
		.out_low   (out_low),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// AES model
	// ------------------------------------------------------------------
	function automatic logic [7:0] gf_dbl(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) p ^= a;
			a = gf_dbl(a);
			b = b >> 1;
		end
		return p;
	endfunction

	function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	// S-box from the GF inverse (x^254) and the affine map
	function automatic void build_sboxes();
		logic [7:0] r;
		logic [7:0] b;
		for (int x = 0; x < 256; x++) begin
			r = 8'h01;
			for (int e = 0; e < 254; e++) r = gf_mul(r, x[7:0]);
			if (x == 0) r = 8'h00;
			b = r ^ rol8(r, 1) ^ rol8(r, 2) ^ rol8(r, 3) ^ rol8(r, 4) ^ 8'h63;
			fwd_sbox[x] = b;
			inv_sbox[b] = x[7:0];
		end
	endfunction

	function automatic void expand_schedule();
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		sched[0] = key_hi[63:32];
		sched[1] = key_hi[31:0];
		sched[2] = key_lo[63:32];
		sched[3] = key_lo[31:0];
		for (int i = 4; i < 44; i++) begin
			t = sched[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_sbox[t[31:24]] ^ rc, fwd_sbox[t[23:16]],
					fwd_sbox[t[15:8]], fwd_sbox[t[7:0]]};
				rc = gf_dbl(rc);
			end
			sched[i] = sched[i-4] ^ t;
		end
	endfunction

	// state byte 4c+r is row r, column c; byte 0 is the top of the block
	function automatic blk_t aes_block(input logic dec, input blk_t din);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a [4];
		logic [7:0] m [4];
		blk_t       res;
		for (int i = 0; i < 16; i++) s[i] = din[127 - 8*i -: 8];
		if (dec) m = '{8'd14, 8'd11, 8'd13, 8'd9};
		else     m = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int step = 0; step <= 10; step++) begin
			int rnd;
			rnd = dec ? 10 - step : step;
			if (step > 0) begin
				// sub bytes and shift rows commute, order is immaterial here
				t = s;
				for (int i = 0; i < 16; i++)
					s[i] = dec ? inv_sbox[t[i]] : fwd_sbox[t[i]];
				t = s;
				for (int r = 1; r < 4; r++)
					for (int c = 0; c < 4; c++)
						s[r + 4*c] = t[r + 4*(dec ? ((c - r + 4) % 4) : ((c + r) % 4))];
			end
			// forward: mix before key add; inverse: key add before mix
			if (!dec && step > 0 && step < 10) begin
				for (int c = 0; c < 4; c++) begin
					for (int k = 0; k < 4; k++) a[k] = s[4*c + k];
					for (int r = 0; r < 4; r++)
						s[4*c + r] = gf_mul(m[(4-r)%4], a[0]) ^ gf_mul(m[(5-r)%4], a[1])
							^ gf_mul(m[(6-r)%4], a[2]) ^ gf_mul(m[(7-r)%4], a[3]);
				end
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					s[4*c + r] ^= sched[rnd*4 + c][31 - 8*r -: 8];
			if (dec && step > 0 && step < 10) begin
				for (int c = 0; c < 4; c++) begin
					for (int k = 0; k < 4; k++) a[k] = s[4*c + k];
					for (int r = 0; r < 4; r++)
						s[4*c + r] = gf_mul(m[(4-r)%4], a[0]) ^ gf_mul(m[(5-r)%4], a[1])
							^ gf_mul(m[(6-r)%4], a[2]) ^ gf_mul(m[(7-r)%4], a[3]);
				end
			end
		end
		for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// ------------------------------------------------------------------
	// stimulus queue helpers
	// ------------------------------------------------------------------
	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic void enqueue_block(input logic act, input logic [63:0] hi,
			input logic [63:0] lo, input int gap);
		entry_t e;
		e = '{kind: ENT_BLOCK, act: act, hi: hi, lo: lo, idx: 2'd0, gap: gap};
		pending_q.push_back(e);
	endfunction

	function automatic void enqueue_key_write(input logic [1:0] idx, input logic [63:0] val);
		entry_t e;
		e = '{kind: ENT_KEY, act: 1'b0, hi: val, lo: 64'd0, idx: idx, gap: 0};
		pending_q.push_back(e);
	endfunction

	function automatic void enqueue_drain();
		entry_t e;
		e = '{kind: ENT_DRAIN, act: 1'b0, hi: 64'd0, lo: 64'd0, idx: 2'd0, gap: 0};
		pending_q.push_back(e);
	endfunction

	// ------------------------------------------------------------------
	// driver: falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive
		logic   n_start;
		logic   n_we;
		entry_t cur;
		n_start = start;
		n_we    = 1'b0;
		if (took) begin
			n_start = 1'b0;
			void'(pending_q.pop_front());
			armed = 1'b0;
			took  = 1'b0;
		end
		if (arst_n && !n_start && pending_q.size() > 0) begin
			cur = pending_q[0];
			case (cur.kind)
			ENT_BLOCK: begin
				if (!armed) begin
					gap_left = cur.gap;
					armed    = 1'b1;
				end
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					n_start = 1'b1;
					action     <= cur.act;
					block_high <= cur.hi;
					block_low  <= cur.lo;
				end
			end
			ENT_KEY: begin
				// key writes only into an empty pipeline
				if (expected_q.size() == 0) begin
					n_we = 1'b1;
					cfg_index <= cur.idx;
					cfg_wdata <= cur.hi;
					void'(pending_q.pop_front());
				end
			end
			default: begin
				if (expected_q.size() == 0) void'(pending_q.pop_front());
			end
			endcase
		end
		start  <= n_start;
		cfg_we <= n_we;
	end

	// ------------------------------------------------------------------
	// monitor and checker: rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		blk_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_KEY_HIGH) key_hi = cfg_wdata;
				if (cfg_index == REG_KEY_LOW) key_lo = cfg_wdata;
				if (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW) expand_schedule();
			end
			took = start && !busy;
			if (took) expected_q.push_back(aes_block(action, {block_high, block_low}));
			if (out_valid) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h_%h", out_high, out_low));
				end else begin
					want = expected_q.pop_front();
					if (out_high !== want[127:64])
						report_mismatch($sformatf("out_high %h, want %h", out_high, want[127:64]));
					if (out_low !== want[63:0])
						report_mismatch($sformatf("out_low %h, want %h", out_low, want[63:0]));
				end
			end
			idle_cnt = (took || out_valid) ? 0 : idle_cnt + 1;
			if (idle_cnt >= WATCHDOG_CYCLES) begin
				$display("watchdog: no transaction for %0d cycles", idle_cnt);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		logic [63:0] kh;
		logic [63:0] kl;
		int          gap;
		start      = 1'b0;
		action     = 1'b0;
		block_high = '0;
		block_low  = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		err_cnt    = 0;
		idle_cnt   = 0;
		took       = 1'b0;
		armed      = 1'b0;
		gap_left   = 0;
		arst_n     = 1'b0;
		build_sboxes();
		key_hi = '0;
		key_lo = '0;
		expand_schedule();

		// directed: reset key, extremes of the block, both actions
		enqueue_block(ACT_ENC, 64'd0, 64'd0, 0);
		enqueue_block(ACT_DEC, 64'd0, 64'd0, 0);
		enqueue_block(ACT_ENC, '1, '1, 0);
		enqueue_block(ACT_DEC, '1, '1, 3);
		enqueue_block(ACT_ENC, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 0);
		enqueue_drain();
		// standard test vector key and plain text
		enqueue_key_write(REG_KEY_HIGH, 64'h0001_0203_0405_0607);
		enqueue_key_write(REG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
		enqueue_block(ACT_ENC, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 0);
		enqueue_block(ACT_DEC, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a, 0);
		enqueue_block(ACT_ENC, 64'd0, '1, 5);
		enqueue_drain();
		// writes past key_low must leave the key alone
		enqueue_key_write(REG_SPARE_2, '1);
		enqueue_key_write(REG_SPARE_3, 64'h5555_aaaa_5555_aaaa);
		enqueue_block(ACT_ENC, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 0);
		enqueue_block(ACT_DEC, '1, 64'd0, 0);
		enqueue_drain();
		enqueue_key_write(REG_KEY_HIGH, '1);
		enqueue_key_write(REG_KEY_LOW, '1);
		enqueue_block(ACT_ENC, 64'd0, 64'd0, 0);
		enqueue_block(ACT_DEC, '1, '1, 0);
		enqueue_block(ACT_ENC, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 0);

		// random phases, a new key each time
		for (int ph = 0; ph < 8; ph++) begin
			enqueue_drain();
			case (ph)
			0: begin kh = '0; kl = '0; end
			1: begin kh = '1; kl = '0; end
			2: begin kh = '0; kl = '1; end
			default: begin kh = rand64(); kl = rand64(); end
			endcase
			enqueue_key_write(REG_KEY_HIGH, kh);
			enqueue_key_write(REG_KEY_LOW, kl);
			if (ph % 3 == 0) enqueue_key_write(ph % 2 ? REG_SPARE_3 : REG_SPARE_2, rand64());
			for (int i = 0; i < 85; i++) begin
				if (ph % 3 == 1 || $urandom_range(0, 2) == 0) gap = 0;
				else gap = $urandom_range(0, 19);
				enqueue_block(1'($urandom_range(0, 1)), rand64(), rand64(), gap);
				if ($urandom_range(0, 40) == 0) enqueue_drain();
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_q.size() == 0 && expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
